### design/rgb_shp_pkg.sv
// Shared types, constants and the sharpen arithmetic of the RGB 3x3 sharpen stream.
package rgb_shp_pkg;

   localparam int MAX_WIDTH    = 1024;
   localparam int HEIGHT_LIMIT = 4096;
   localparam int COL_W        = $clog2(MAX_WIDTH);
   localparam int ROW_W        = $clog2(HEIGHT_LIMIT);
   localparam int FW_W         = 11;
   localparam int FH_W         = 13;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_IDX_W    = 1;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = 11'd640;
   localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   typedef pixel_type [2:0] column_type;
   typedef column_type [2:0] window_type;

   typedef struct packed {
      pixel_type upper;
      pixel_type middle;
   } line_word_type;

   localparam int LINE_W = $bits(line_word_type);

   typedef struct packed {
      window_type       window;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic             last_col;
      logic             last_row;
   } entry_type;

   function automatic logic [7:0] sharpen_clamp(input logic [7:0] ctr, input logic [10:0] nsum);
      logic [11:0]        nine;
      logic signed [12:0] acc;
      nine = {1'b0, ctr, 3'b000} + {4'b0000, ctr};
      acc  = $signed({1'b0, nine}) - $signed({2'b00, nsum});
      if (acc < 13'sd0) begin
         return 8'd0;
      end else if (acc > 13'sd255) begin
         return 8'hff;
      end else begin
         return acc[7:0];
      end
   endfunction

endpackage

### design/rgb_shp_ifs.sv
// Valid/ready channel interfaces for pixels in and sharpened results out.
interface rgb_shp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_in;
   logic [7:0] green_in;
   logic [7:0] blue_in;

   modport source(output valid, output red_in, output green_in, output blue_in, input ready);
   modport sink(input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

interface rgb_shp_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [7:0]                     red_out;
   logic [7:0]                     green_out;
   logic [7:0]                     blue_out;
   logic [rgb_shp_pkg::COL_W-1:0]  out_col;
   logic [rgb_shp_pkg::ROW_W-1:0]  out_row;
   logic                           run_last;
   logic                           frame_done;

   modport source(output valid, output red_out, output green_out, output blue_out,
                  output out_col, output out_row, output run_last, output frame_done,
                  input ready);
   modport sink(input valid, input red_out, input green_out, input blue_out,
                input out_col, input out_row, input run_last, input frame_done,
                output ready);
endinterface

### design/rgb_shp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rgb_shp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/rgb_shp_front.sv
// Front end: config registers, raster counters, line store and 3x3 window, queue push.
module rgb_shp_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [rgb_shp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rgb_shp_pkg::CSR_DATA_W-1:0] csr_wdata,
   rgb_shp_req_if.sink                        req_port,
   output logic                               push_valid,
   input  logic                               push_ready,
   output rgb_shp_pkg::entry_type             push_entry
);
   import rgb_shp_pkg::*;

   logic [FW_W-1:0]   frame_width_ff, frame_width_in;
   logic [FH_W-1:0]   frame_height_ff, frame_height_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  wm1;
   logic [ROW_W-1:0]  hm1;
   logic              accept;

   logic              s1_valid_ff, s1_valid_in;
   pixel_type         s1_pix_ff;
   logic [COL_W-1:0]  s1_col_ff;
   logic [ROW_W-1:0]  s1_row_ff;
   logic              s1_last_col_ff;
   logic              s1_last_row_ff;
   logic              s1_emit_ff;
   logic              s1_advance;

   logic [LINE_W-1:0] line_rd_raw;
   line_word_type     line_rd;
   line_word_type     line_wr;
   window_type        window_ff, window_in;
   window_type        shifted;

   always_comb begin
      if (int'(frame_width_ff) > MAX_WIDTH) begin
         wm1 = COL_W'(MAX_WIDTH - 1);
      end else if (frame_width_ff < FW_W'(2)) begin
         wm1 = COL_W'(1);
      end else begin
         wm1 = COL_W'(frame_width_ff - FW_W'(1));
      end
      if (int'(frame_height_ff) > HEIGHT_LIMIT) begin
         hm1 = ROW_W'(HEIGHT_LIMIT - 1);
      end else if (frame_height_ff < FH_W'(2)) begin
         hm1 = ROW_W'(1);
      end else begin
         hm1 = ROW_W'(frame_height_ff - FH_W'(1));
      end
   end

   assign s1_advance     = s1_valid_ff && (!s1_emit_ff || push_ready);
   assign req_port.ready = !s1_valid_ff || s1_advance;
   assign accept         = req_port.valid && req_port.ready;

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      col_in          = col_ff;
      row_in          = row_ff;
      if (csr_we) begin
         case (csr_index)
            REG_FRAME_WIDTH: begin
               frame_width_in = csr_wdata[FW_W-1:0];
            end
            REG_FRAME_HEIGHT: begin
               frame_height_in = csr_wdata[FH_W-1:0];
            end
            default: begin
            end
         endcase
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_ff == wm1) begin
            col_in = '0;
            row_in = (row_ff == hm1) ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
         col_ff          <= '0;
         row_ff          <= '0;
         s1_valid_ff     <= 1'b0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         col_ff          <= col_in;
         row_ff          <= row_in;
         s1_valid_ff     <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff.red   <= req_port.red_in;
         s1_pix_ff.green <= req_port.green_in;
         s1_pix_ff.blue  <= req_port.blue_in;
         s1_col_ff       <= col_ff;
         s1_row_ff       <= row_ff;
         s1_last_col_ff  <= (col_ff == wm1);
         s1_last_row_ff  <= (row_ff == hm1);
         s1_emit_ff      <= (col_ff != '0) && (row_ff != '0);
      end
      window_ff <= window_in;
   end

   rgb_shp_ram #(
      .WIDTH(LINE_W),
      .DEPTH(MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_advance),
      .wr_addr (s1_col_ff),
      .wr_data (line_wr),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (line_rd_raw)
   );

   assign line_rd        = line_rd_raw;
   assign line_wr.upper  = line_rd.middle;
   assign line_wr.middle = s1_pix_ff;

   always_comb begin
      shifted[0]    = window_ff[1];
      shifted[1]    = window_ff[2];
      shifted[2][0] = line_rd.upper;
      shifted[2][1] = line_rd.middle;
      shifted[2][2] = s1_pix_ff;
      window_in     = s1_advance ? shifted : window_ff;
   end

   assign push_valid          = s1_valid_ff && s1_emit_ff;
   assign push_entry.window   = shifted;
   assign push_entry.col      = s1_col_ff;
   assign push_entry.row      = s1_row_ff;
   assign push_entry.last_col = s1_last_col_ff;
   assign push_entry.last_row = s1_last_row_ff;

   a_col_in_frame: assert property (@(posedge clock) disable iff (reset)
      col_ff <= wm1) else $error("column counter beyond frame width");

   a_row_in_frame: assert property (@(posedge clock) disable iff (reset)
      row_ff <= hm1) else $error("row counter beyond frame height");

   a_push_has_left_and_top: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> (push_entry.col != '0 && push_entry.row != '0))
      else $error("window pushed without a left column and an upper row");

endmodule

### design/rgb_shp_queue.sv
// Short queue of window entries between front and back.
module rgb_shp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  rgb_shp_pkg::entry_type push_entry,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output rgb_shp_pkg::entry_type pop_entry
);
   import rgb_shp_pkg::*;

   entry_type         mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign push_ready = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_entry  = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_pop_only_when_filled: assert property (@(posedge clock) disable iff (reset)
      pop_ready |-> pop_valid) else $error("queue popped while empty");

endmodule

### design/rgb_shp_back.sv
// Back end: walks the results of each window entry and computes the sharpened pixel.
module rgb_shp_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   pop_valid,
   output logic                   pop_ready,
   input  rgb_shp_pkg::entry_type pop_entry,
   rgb_shp_rsp_if.source          rsp_port
);
   import rgb_shp_pkg::*;

   logic [1:0]       k_ff, k_in;
   logic [1:0]       k_last;
   logic             is_last;
   logic             step;
   logic             xb;
   logic             yb;
   logic [1:0]       xs [3];
   logic [1:0]       ys [3];
   pixel_type        taps [3][3];
   logic [10:0]      nsum_r, nsum_g, nsum_b;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_red_ff;
   logic [7:0]       rsp_green_ff;
   logic [7:0]       rsp_blue_ff;
   logic [COL_W-1:0] rsp_col_ff;
   logic [ROW_W-1:0] rsp_row_ff;
   logic             rsp_run_last_ff;
   logic             rsp_frame_done_ff;

   assign k_last    = {pop_entry.last_row, pop_entry.last_col};
   assign is_last   = k_ff == k_last;
   assign step      = pop_valid && (!rsp_valid_ff || rsp_port.ready);
   assign pop_ready = step && is_last;
   assign xb        = k_ff[0];
   assign yb        = k_ff[1];

   always_comb begin
      k_in = k_ff;
      if (step) begin
         if (is_last) begin
            k_in = 2'd0;
         end else if (pop_entry.last_col) begin
            k_in = k_ff + 2'd1;
         end else begin
            k_in = k_ff + 2'd2;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      xs[0] = xb ? 2'd1 : ((pop_entry.col == COL_W'(1)) ? 2'd1 : 2'd0);
      xs[1] = xb ? 2'd2 : 2'd1;
      xs[2] = 2'd2;
      ys[0] = yb ? 2'd1 : ((pop_entry.row == ROW_W'(1)) ? 2'd1 : 2'd0);
      ys[1] = yb ? 2'd2 : 2'd1;
      ys[2] = 2'd2;
      nsum_r = '0;
      nsum_g = '0;
      nsum_b = '0;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            taps[i][j] = pop_entry.window[xs[i]][ys[j]];
            if (i != 1 || j != 1) begin
               nsum_r = nsum_r + {3'b000, taps[i][j].red};
               nsum_g = nsum_g + {3'b000, taps[i][j].green};
               nsum_b = nsum_b + {3'b000, taps[i][j].blue};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff         <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_red_ff        <= sharpen_clamp(taps[1][1].red, nsum_r);
         rsp_green_ff      <= sharpen_clamp(taps[1][1].green, nsum_g);
         rsp_blue_ff       <= sharpen_clamp(taps[1][1].blue, nsum_b);
         rsp_col_ff        <= xb ? pop_entry.col : pop_entry.col - COL_W'(1);
         rsp_row_ff        <= yb ? pop_entry.row : pop_entry.row - ROW_W'(1);
         rsp_run_last_ff   <= is_last;
         rsp_frame_done_ff <= xb && yb;
      end
   end

   assign rsp_port.valid      = rsp_valid_ff;
   assign rsp_port.red_out    = rsp_red_ff;
   assign rsp_port.green_out  = rsp_green_ff;
   assign rsp_port.blue_out   = rsp_blue_ff;
   assign rsp_port.out_col    = rsp_col_ff;
   assign rsp_port.out_row    = rsp_row_ff;
   assign rsp_port.run_last   = rsp_run_last_ff;
   assign rsp_port.frame_done = rsp_frame_done_ff;

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_frame_done_ff |-> rsp_run_last_ff)
      else $error("frame end not flagged as last result of its pixel");

   a_index_allowed: assert property (@(posedge clock) disable iff (reset)
      pop_valid |-> (k_ff & ~k_last) == 2'd0)
      else $error("result index outside the results of this entry");

endmodule

### design/rgb_sharpen_3x3_stream_unit.sv
// Top level of the streaming RGB 3x3 sharpen unit.
// Throughput: one pixel and one rsp result per cycle while rsp is ready, so pixels of the
// final column or row (two or four results) hold the front back through the four-entry queue.
// Reset: synchronous; clears counters, queue and handshakes, loads a 640 x 480 frame size;
// the line store is not cleared.
module rgb_sharpen_3x3_stream_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [rgb_shp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rgb_shp_pkg::CSR_DATA_W-1:0] csr_wdata,
   rgb_shp_req_if.sink                        req_port,
   rgb_shp_rsp_if.source                      rsp_port
);
   import rgb_shp_pkg::*;

   logic      push_valid;
   logic      push_ready;
   entry_type push_entry;
   logic      pop_valid;
   logic      pop_ready;
   entry_type pop_entry;

   rgb_shp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_port   (req_port),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   rgb_shp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   rgb_shp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry),
      .rsp_port  (rsp_port)
   );

endmodule

### verif/rgb_sharpen_3x3_stream_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the RGB 3x3 sharpen stream: directed, random and clamped frames.
module rgb_sharpen_3x3_stream_unit_tb;
   import rgb_shp_pkg::*;

   localparam int HALF_PERIOD  = 2;
   localparam int RESET_CYCLES = 6;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES  = 120;
   localparam int RANDOM_ITEMS = 320;
   localparam int CYCLE_LIMIT  = 500000;

   typedef struct packed {
      pixel_type        color;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic             run_last;
      logic             frame_done;
   } sharp_result_type;

   typedef struct packed {
      logic                  is_csr;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] data;
      pixel_type             pix;
      logic                  fixed;
   } plan_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   rgb_shp_req_if req_if();
   rgb_shp_rsp_if rsp_if();

   rgb_sharpen_3x3_stream_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_port  (req_if),
      .rsp_port  (rsp_if)
   );

   logic [FW_W-1:0] fw_raw;
   logic [FH_W-1:0] fh_raw;
   pixel_type       upper_row [MAX_WIDTH];
   pixel_type       middle_row [MAX_WIDTH];
   pixel_type       win [9];
   int              col_ct;
   int              row_ct;

   sharp_result_type sharpened_q [$];
   plan_row_type     plan_q [$];
   sharp_result_type mon_want;

   int              err_count = 0;
   int unsigned     cycle_ct = 0;
   int              send_idle_pct = 0;
   int              recv_idle_pct = 0;
   logic            hold_request;

   always #(HALF_PERIOD) clock = ~clock;

   function automatic int bound(input int v, input int lo, input int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic int eff_width();
      return bound(int'(fw_raw), 2, MAX_WIDTH);
   endfunction

   function automatic int eff_height();
      return bound(int'(fh_raw), 2, HEIGHT_LIMIT);
   endfunction

   function automatic logic [7:0] sharpen_chan(input int x, input int y, input int c,
                                               input int r, input int w, input int h,
                                               input int ch);
      int        acc;
      int        dx;
      int        dy;
      int        sx;
      int        sy;
      int        v;
      pixel_type t;
      acc = 0;
      for (dy = -1; dy <= 1; dy++) begin
         for (dx = -1; dx <= 1; dx++) begin
            sx = bound(bound(x + dx, 0, w - 1) - (c - 2), 0, 2);
            sy = bound(bound(y + dy, 0, h - 1) - (r - 2), 0, 2);
            t = win[sx * 3 + sy];
            v = (ch == 0) ? int'(t.red) : ((ch == 1) ? int'(t.green) : int'(t.blue));
            if (dx == 0 && dy == 0) acc += 9 * v;
            else acc -= v;
         end
      end
      return 8'(bound(acc, 0, 255));
   endfunction

   function automatic sharp_result_type make_result(input int x, input int y, input int c,
                                                    input int r, input int w, input int h,
                                                    input pixel_type p, input logic fixed);
      sharp_result_type res;
      if (fixed) res.color = p;
      else res.color = {sharpen_chan(x, y, c, r, w, h, 0), sharpen_chan(x, y, c, r, w, h, 1),
                        sharpen_chan(x, y, c, r, w, h, 2)};
      res.col        = x[COL_W-1:0];
      res.row        = y[ROW_W-1:0];
      res.run_last   = 1'b0;
      res.frame_done = (x == w - 1 && y == h - 1);
      return res;
   endfunction

   // fixed: the frame is uniform, so every result carries the input color itself
   task automatic predict_sharpened(input pixel_type p, input logic fixed);
      sharp_result_type batch [4];
      int               n;
      int               k;
      int               w;
      int               h;
      int               c;
      int               r;
      w = eff_width();
      h = eff_height();
      c = col_ct;
      r = row_ct;
      if (c >= w) c = 0;
      if (r >= h) r = 0;
      for (k = 0; k < 3; k++) begin
         win[k]     = win[3 + k];
         win[3 + k] = win[6 + k];
      end
      win[6] = upper_row[c];
      win[7] = middle_row[c];
      win[8] = p;
      upper_row[c]  = middle_row[c];
      middle_row[c] = p;
      n = 0;
      if (r >= 1 && c >= 1) begin
         batch[n++] = make_result(c - 1, r - 1, c, r, w, h, p, fixed);
         if (c == w - 1) batch[n++] = make_result(c, r - 1, c, r, w, h, p, fixed);
         if (r == h - 1) begin
            batch[n++] = make_result(c - 1, r, c, r, w, h, p, fixed);
            if (c == w - 1) batch[n++] = make_result(c, r, c, r, w, h, p, fixed);
         end
         batch[n - 1].run_last = 1'b1;
      end
      for (k = 0; k < n; k++) sharpened_q.push_back(batch[k]);
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      col_ct = c;
      row_ct = r;
   endtask

   function automatic logic [7:0] rand_level();
      case ($urandom_range(3))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic pixel_type rand_pixel();
      pixel_type p;
      p.red   = rand_level();
      p.green = rand_level();
      p.blue  = rand_level();
      return p;
   endfunction

   function automatic void add_pixel(input logic [7:0] r, input logic [7:0] g,
                                     input logic [7:0] b, input logic fixed);
      plan_row_type row;
      row.is_csr = 1'b0;
      row.idx    = '0;
      row.data   = '0;
      row.pix    = {r, g, b};
      row.fixed  = fixed;
      plan_q.push_back(row);
   endfunction

   function automatic void add_csr(input logic [CSR_IDX_W-1:0] idx,
                                   input logic [CSR_DATA_W-1:0] data);
      plan_row_type row;
      row.is_csr = 1'b1;
      row.idx    = idx;
      row.data   = data;
      row.pix    = '0;
      row.fixed  = 1'b0;
      plan_q.push_back(row);
   endfunction

   task automatic settle_block();
      while (sharpened_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      req_if.valid <= 1'b0;
      settle_block();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == REG_FRAME_WIDTH) fw_raw = data[FW_W-1:0];
      else fh_raw = data[FH_W-1:0];
      col_ct = 0;
      row_ct = 0;
   endtask

   task automatic send_pixel(input pixel_type p, input logic fixed);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.red_in   <= p.red;
      req_if.green_in <= p.green;
      req_if.blue_in  <= p.blue;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      predict_sharpened(p, fixed);
   endtask

   task automatic check_field(input string what, input logic [15:0] want, input logic [15:0] got);
      if (want !== got) begin
         err_count++;
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin
      cycle_ct <= cycle_ct + 1;
      if (cycle_ct > CYCLE_LIMIT) begin
         $display("%0t: timeout", $time);
         $display("FAIL rgb_sharpen_3x3_stream_unit");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (sharpened_q.size() == 0) begin
            err_count++;
            $display("%0t: unexpected transfer: expected none, actual col %0d row %0d",
                     $time, rsp_if.out_col, rsp_if.out_row);
         end else begin
            mon_want = sharpened_q.pop_front();
            check_field("red_out", 16'(mon_want.color.red), 16'(rsp_if.red_out));
            check_field("green_out", 16'(mon_want.color.green), 16'(rsp_if.green_out));
            check_field("blue_out", 16'(mon_want.color.blue), 16'(rsp_if.blue_out));
            check_field("out_col", 16'(mon_want.col), 16'(rsp_if.out_col));
            check_field("out_row", 16'(mon_want.row), 16'(rsp_if.out_row));
            check_field("run_last", 16'(mon_want.run_last), 16'(rsp_if.run_last));
            check_field("frame_done", 16'(mon_want.frame_done), 16'(rsp_if.frame_done));
         end
      end
   end

   initial begin : rsp_drain
      int   hold_left;
      logic hold_served;
      hold_left   = 0;
      hold_served = 1'b0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (hold_request === 1'b1 && !hold_served) begin
            hold_served = 1'b1;
            hold_left   = HOLD_CYCLES;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin : stimulus
      int           i;
      int           small_items;
      int           w_new;
      int           h_new;
      int           which;
      int           npix;
      int           frame_px;
      logic         pressure_armed;
      plan_row_type prow;

      reset           <= 1'b1;
      csr_we          <= 1'b0;
      csr_index       <= '0;
      csr_wdata       <= '0;
      req_if.valid    <= 1'b0;
      req_if.red_in   <= '0;
      req_if.green_in <= '0;
      req_if.blue_in  <= '0;
      hold_request    <= 1'b0;

      fw_raw = FRAME_WIDTH_RESET;
      fh_raw = FRAME_HEIGHT_RESET;
      col_ct = 0;
      row_ct = 0;
      for (i = 0; i < 9; i++) win[i] = '0;
      for (i = 0; i < MAX_WIDTH; i++) begin
         upper_row[i]  = '0;
         middle_row[i] = '0;
      end

      // two pixels at the reset frame size: still row 0, no results
      add_pixel(8'd7, 8'd8, 8'd9, 1'b0);
      add_pixel(8'd255, 8'd255, 8'd255, 1'b0);
      add_csr(REG_FRAME_WIDTH, 13'd2);
      add_csr(REG_FRAME_HEIGHT, 13'd2);
      for (i = 0; i < 4; i++) add_pixel(8'd255, 8'd255, 8'd255, 1'b1);
      for (i = 0; i < 4; i++) add_pixel(8'd0, 8'd0, 8'd0, 1'b1);
      add_pixel(8'd255, 8'd0, 8'd255, 1'b0);
      add_pixel(8'd0, 8'd255, 8'd0, 1'b0);
      add_pixel(8'd255, 8'd255, 8'd0, 1'b0);
      add_pixel(8'd0, 8'd0, 8'd255, 1'b0);
      add_csr(REG_FRAME_WIDTH, 13'd3);
      add_csr(REG_FRAME_HEIGHT, 13'd3);
      for (i = 0; i < 9; i++) begin
         if (i == 4) add_pixel(8'd200, 8'd100, 8'd30, 1'b0);
         else add_pixel(8'd0, 8'd0, 8'd0, 1'b0);
      end

      send_idle_pct = 13;
      recv_idle_pct = 75;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < plan_q.size(); i++) begin
         prow = plan_q[i];
         if (prow.is_csr) write_reg(prow.idx, prow.data);
         else send_pixel(prow.pix, prow.fixed);
      end

      small_items    = 0;
      pressure_armed = 1'b0;
      while (small_items < RANDOM_ITEMS) begin
         if (small_items < RANDOM_ITEMS / 3) begin
            send_idle_pct = 13;
            recv_idle_pct = 75;
         end else if (small_items < 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 75;
            recv_idle_pct = 13;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (send_idle_pct == 0 && !pressure_armed) begin
            // long receiver hold-off while a tall frame keeps coming
            pressure_armed = 1'b1;
            write_reg(REG_FRAME_WIDTH, 13'd4);
            write_reg(REG_FRAME_HEIGHT, 13'd12);
            hold_request <= 1'b1;
            npix = 48;
         end else begin
            w_new = $urandom_range(2, 8);
            h_new = $urandom_range(2, 6);
            case ($urandom_range(9))
               0: w_new = $urandom_range(0, 1);
               1: h_new = $urandom_range(0, 1);
               default: ;
            endcase
            which = $urandom_range(3);
            if (which != 1) write_reg(REG_FRAME_WIDTH, CSR_DATA_W'(w_new));
            if (which != 0) write_reg(REG_FRAME_HEIGHT, CSR_DATA_W'(h_new));
            frame_px = eff_width() * eff_height();
            if ($urandom_range(4) == 0) npix = $urandom_range(1, frame_px - 1);
            else npix = frame_px * $urandom_range(1, 2);
         end
         for (i = 0; i < npix; i++) send_pixel(rand_pixel(), 1'b0);
         small_items += npix;
      end

      // widest frame, clamped from an all-ones write, start of its first row
      write_reg(REG_FRAME_WIDTH, 13'h1fff);
      write_reg(REG_FRAME_HEIGHT, 13'h0000);
      for (i = 0; i < 40; i++) send_pixel(rand_pixel(), 1'b0);

      // tallest frame, clamped, only its top rows
      write_reg(REG_FRAME_WIDTH, 13'd2);
      write_reg(REG_FRAME_HEIGHT, 13'h1fff);
      for (i = 0; i < 40; i++) send_pixel(rand_pixel(), 1'b0);

      req_if.valid <= 1'b0;
      settle_block();
      if (err_count == 0) begin
         $display("PASS rgb_sharpen_3x3_stream_unit");
      end else begin
         $display("FAIL rgb_sharpen_3x3_stream_unit");
      end
      $finish;
   end

endmodule

### rgb_sharpen_3x3_stream_unit.f
design/rgb_shp_pkg.sv
design/rgb_shp_ifs.sv
design/rgb_shp_ram.sv
design/rgb_shp_front.sv
design/rgb_shp_queue.sv
design/rgb_shp_back.sv
design/rgb_sharpen_3x3_stream_unit.sv
verif/rgb_sharpen_3x3_stream_unit_tb.sv
